/* rtl/assert_macros.svh */
// Assertion macros shared by the decoder modules.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/b64d_pkg.sv */
`timescale 1ns / 1ps
package b64d_pkg;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BADCHAR = 2'd1,
		ST_BADLEN  = 2'd2,
		ST_BADPAD  = 2'd3
	} status_t;

	// Pad character of the alphabet.
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// Depth of the group record queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	// One transaction from the front to the back: a decoded group or an error.
	typedef struct packed {
		logic [23:0] triple;
		logic [1:0]  nbytes;
		status_t     status;
		logic        last;
	} grp_rec_t;

	// Maps a character to {valid, six-bit value}; the pad maps to zero.
	function automatic logic [6:0] b64_map(input logic [7:0] c);
		logic [7:0] d;
		logic [6:0] r;
		d = 8'd0;
		r = 7'd0;
		case (c) inside
			[8'h41:8'h5A]: begin
				d = c - 8'h41;
				r = {1'b1, d[5:0]};
			end
			[8'h61:8'h7A]: begin
				d = c - 8'h61 + 8'd26;
				r = {1'b1, d[5:0]};
			end
			[8'h30:8'h39]: begin
				d = c - 8'h30 + 8'd52;
				r = {1'b1, d[5:0]};
			end
			8'h2B: r = {1'b1, 6'd62};
			8'h2F: r = {1'b1, 6'd63};
			PAD_CHAR: r = {1'b1, 6'd0};
			default: r = 7'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/b64d_front.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module b64d_front
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] char_code,
	input  logic       end_of_text,
	output logic       rec_push,
	output grp_rec_t   rec
);

	logic [17:0] sextets_q;
	logic [1:0]  group_pos_q;
	logic [2:0]  pads_q;
	logic        error_seen_q;

	logic [6:0]  mapped;
	logic        char_ok;
	logic        is_pad;
	logic [2:0]  pads_base;
	logic [2:0]  pads_new;

	// Character classification and the trailing pad run of the group.
	always_comb begin
		mapped    = b64_map(char_code);
		char_ok   = mapped[6];
		is_pad    = (char_code == PAD_CHAR);
		pads_base = (group_pos_q == 2'd0) ? 3'd0 : pads_q;
		if (!is_pad) begin
			pads_new = 3'd0;
		end else if (pads_base != 3'd7) begin
			pads_new = pads_base + 3'd1;
		end else begin
			pads_new = pads_base;
		end
	end

	// Record for the back: a closed group or an error report.
	always_comb begin
		rec_push    = 1'b0;
		rec.triple  = {sextets_q, mapped[5:0]};
		rec.nbytes  = 2'd1;
		rec.status  = ST_OK;
		rec.last    = 1'b1;
		if (accept && !error_seen_q) begin
			if (end_of_text && group_pos_q != 2'd3) begin
				rec_push   = 1'b1;
				rec.triple = 24'd0;
				rec.status = ST_BADLEN;
			end else if (!char_ok) begin
				rec_push   = 1'b1;
				rec.triple = 24'd0;
				rec.status = ST_BADCHAR;
			end else if (group_pos_q == 2'd3) begin
				rec_push = 1'b1;
				if (end_of_text && pads_new > 3'd2) begin
					rec.triple = 24'd0;
					rec.status = ST_BADPAD;
				end else if (end_of_text) begin
					rec.nbytes = 2'd3 - pads_new[1:0];
				end else begin
					rec.nbytes = 2'd3;
					rec.last   = 1'b0;
				end
			end
		end
	end

	// Group state update. An invalid character that is not the final one starts
	// dropping, whatever its place in the group.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sextets_q    <= 18'd0;
			group_pos_q  <= 2'd0;
			pads_q       <= 3'd0;
			error_seen_q <= 1'b0;
		end else if (accept) begin
			if (error_seen_q || end_of_text || (group_pos_q == 2'd3 && char_ok)) begin
				sextets_q    <= 18'd0;
				group_pos_q  <= 2'd0;
				pads_q       <= 3'd0;
				error_seen_q <= error_seen_q && !end_of_text;
			end else if (!char_ok) begin
				sextets_q    <= 18'd0;
				group_pos_q  <= 2'd0;
				pads_q       <= 3'd0;
				error_seen_q <= 1'b1;
			end else begin
				sextets_q   <= {sextets_q[11:0], mapped[5:0]};
				group_pos_q <= group_pos_q + 2'd1;
				pads_q      <= pads_new;
			end
		end
	end

	// The final character always returns the front to its idle state.
	`ASSERT_NEXT(a_end_clears, accept && end_of_text, group_pos_q == 2'd0 && !error_seen_q, "front state not cleared after end of text")
	// A pad run never reaches past the four characters of one group.
	`ASSERT_ALWAYS(a_pads_bound, pads_q <= 3'd3, "pad run exceeds group")

endmodule

/* rtl/b64d_queue.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module b64d_queue
	import b64d_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  grp_rec_t wr_rec,
	input  logic     pop,
	output logic     full,
	output logic     not_empty,
	output grp_rec_t head
);

	grp_rec_t                 slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]      wr_ptr_q;
	logic [QUEUE_AW-1:0]      rd_ptr_q;
	logic [QUEUE_AW:0]        count_q;

	assign full      = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];

	// Record storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_rec;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// The front never writes into a full queue, and the back never reads an empty one.
	`ASSERT_IMPLIES(a_no_overflow, full, !push, "push into full record queue")
	`ASSERT_IMPLIES(a_no_underflow, !not_empty, !pop, "pop from empty record queue")

endmodule

/* rtl/b64d_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module b64d_back
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rec_valid,
	input  grp_rec_t   head,
	output logic       rec_pop,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] data_byte,
	output logic [1:0] status,
	output logic       final_result
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] data_q;
	logic [1:0] status_q;
	logic       final_q;

	logic       load;
	logic       last_byte;
	logic [7:0] sel_byte;

	// Pick the next byte of the head record, most significant first.
	always_comb begin
		load      = rec_valid && (!out_valid_q || pop);
		last_byte = (idx_q == head.nbytes - 2'd1);
		rec_pop   = load && last_byte;
		case (idx_q)
			2'd0:    sel_byte = head.triple[23:16];
			2'd1:    sel_byte = head.triple[15:8];
			default: sel_byte = head.triple[7:0];
		endcase
	end

	// Output register and byte counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last_byte ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q   <= sel_byte;
			status_q <= head.status;
			final_q  <= head.last && last_byte;
		end
	end

	assign empty        = !out_valid_q;
	assign data_byte    = data_q;
	assign status       = status_q;
	assign final_result = final_q;

	// Every record carries at least one result, and an error record exactly one final one.
	`ASSERT_IMPLIES(a_rec_nonempty, rec_valid, head.nbytes != 2'd0, "record with no bytes")
	`ASSERT_IMPLIES(a_err_single, rec_valid && head.status != ST_OK, head.nbytes == 2'd1 && head.last, "malformed error record")

endmodule

/* rtl/base64_stream_decoder.sv */
`timescale 1ns / 1ps
// Streaming Base64 decoder (standard alphabet). It takes one character per clock cycle
// through a push/full port, with end_of_text on the last character, and delivers decoded
// bytes, or a single error transaction, through an empty/pop port, one per cycle. The
// front classifies characters and closes a group every fourth character; each group or
// error becomes one record in a four-entry queue, and the back turns a record into up to
// three byte transactions through an output register. Each byte is held in a queue record
// and then in the output register before it reaches the port. Input is taken every cycle
// as long as the back keeps pace, which it does since four characters give at most three
// bytes; when pop stalls, the queue fills and full rises.
module base64_stream_decoder
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_code,
	input  logic       end_of_text,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] data_byte,
	output logic [1:0] status,
	output logic       final_result
);

	logic     accept;
	logic     rec_push;
	grp_rec_t rec;
	logic     q_full;
	logic     q_not_empty;
	grp_rec_t q_head;
	logic     q_pop;

	assign full   = q_full;
	assign accept = push && !q_full;

	b64d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.rec_push    (rec_push),
		.rec         (rec)
	);

	b64d_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rec_push),
		.wr_rec    (rec),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	b64d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec_valid    (q_not_empty),
		.head         (q_head),
		.rec_pop      (q_pop),
		.empty        (empty),
		.pop          (pop),
		.data_byte    (data_byte),
		.status       (status),
		.final_result (final_result)
	);

endmodule
